// ----- hdl/htfc_pkg.sv -----
package htfc_pkg;

   // Frame status codes as reported on the response channel.
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_RX_FAIL = 2'd1,
      STATUS_CRC_BAD = 2'd2
   } status_type;

   // One finished frame, handed from the byte checker to the scaling pipeline.
   typedef struct packed {
      status_type  status;
      logic [15:0] raw_temperature;
      logic [15:0] raw_humidity;
   } job_type;

endpackage

// ----- hdl/htfc_if.sv -----
interface htfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       frame_start;
   logic       receive_failed;

   modport source (output valid, byte_value, frame_start, receive_failed, input ready);
   modport sink   (input valid, byte_value, frame_start, receive_failed, output ready);
endinterface

interface htfc_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [14:0] temperature_centi;
   logic [13:0]        humidity_centi;
   logic [15:0]        raw_temperature;
   logic [15:0]        raw_humidity;

   modport source (output valid, status, temperature_centi, humidity_centi,
                   raw_temperature, raw_humidity, input ready);
   modport sink   (input valid, status, temperature_centi, humidity_centi,
                   raw_temperature, raw_humidity, output ready);
endinterface

// ----- hdl/humidity_temp_frame_checker_top.sv -----
// Sensor frame checker: one frame byte per request, one response per frame.
// Throughput: one request per clock, sustained, while responses are taken.
// The response for a frame's last byte (or a failed receive) passes, once that request is
// accepted, through the queue (written at the accepting edge), then the multiply stage,
// the divide stage and the output register.
// Reset (synchronous, active high) empties the queue and pipeline and restarts at byte 0.
module humidity_temp_frame_checker_top #(
   parameter int QueueDepth = 2
) (
   input  logic       clock,
   input  logic       reset,
   htfc_req_if.sink   req_ch,
   htfc_rsp_if.source rsp_ch
);
   import htfc_pkg::*;

   // The front end walks the six frame bytes: temperature MSB, LSB and CRC,
   // then humidity MSB, LSB and CRC. It keeps the running CRC-8 (poly 0x31,
   // seed 0xFF) and decides the frame status. It takes a request whenever the
   // queue has room, so the request side waits on the arithmetic only once the queue is full.
   logic    push;
   job_type push_job;
   logic    queue_full;
   logic    queue_not_empty;
   job_type head_job;
   logic    job_take;

   htfc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   // A short queue of finished frames decouples the byte checker from the
   // scaling pipeline, so a stalled response side only holds off requests once
   // the queue fills.
   htfc_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (job_take),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_job  (head_job)
   );

   // The back end scales the raw words to hundredths: one constant multiply,
   // then a divide by 65535 done as an estimate plus a single correction, and
   // a registered response. Values are forced to zero unless the status is ok.
   htfc_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .job_valid (queue_not_empty),
      .job       (head_job),
      .job_take  (job_take),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ----- hdl/htfc_front.sv -----
module htfc_front (
   input  logic             clock,
   input  logic             reset,
   htfc_req_if.sink         req_ch,
   input  logic             queue_full,
   output logic             push,
   output htfc_pkg::job_type push_job
);
   import htfc_pkg::*;

   localparam logic [7:0] CrcPoly  = 8'h31;
   localparam logic [7:0] CrcInit  = 8'hFF;
   localparam logic [2:0] LastByte = 3'd5;

   // CRC-8, MSB first, no reflection, no final XOR.
   function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] r;
      r = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         r = r[7] ? ((r << 1) ^ CrcPoly) : (r << 1);
      end
      return r;
   endfunction

   logic [2:0]  pos_ff, pos_in, pos_eff;
   logic [7:0]  crc_ff, crc_in, crc_eff;
   logic [15:0] temp_word_ff, temp_word_in;
   logic [15:0] hum_word_ff, hum_word_in;
   logic        first_good_ff, first_good_in;
   logic        accept;
   logic        restart;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign restart      = req_ch.frame_start || (pos_ff > LastByte);
   assign pos_eff      = restart ? 3'd0 : pos_ff;
   assign crc_eff      = restart ? CrcInit : crc_ff;

   always_comb begin
      pos_in        = pos_ff;
      crc_in        = crc_ff;
      temp_word_in  = temp_word_ff;
      hum_word_in   = hum_word_ff;
      first_good_in = first_good_ff;
      push          = 1'b0;
      push_job      = '{status: STATUS_OK, raw_temperature: 16'd0, raw_humidity: 16'd0};
      if (accept) begin
         if (req_ch.receive_failed) begin
            pos_in          = 3'd0;
            crc_in          = CrcInit;
            push            = 1'b1;
            push_job.status = STATUS_RX_FAIL;
         end else begin
            pos_in = pos_eff + 3'd1;
            case (pos_eff)
               3'd0: begin
                  temp_word_in = {req_ch.byte_value, 8'h00};
                  crc_in       = crc_update(crc_eff, req_ch.byte_value);
               end
               3'd1: begin
                  temp_word_in = {temp_word_ff[15:8], req_ch.byte_value};
                  crc_in       = crc_update(crc_eff, req_ch.byte_value);
               end
               3'd2: begin
                  first_good_in = (crc_eff == req_ch.byte_value);
                  crc_in        = CrcInit;
               end
               3'd3: begin
                  hum_word_in = {req_ch.byte_value, 8'h00};
                  crc_in      = crc_update(crc_eff, req_ch.byte_value);
               end
               3'd4: begin
                  hum_word_in = {hum_word_ff[15:8], req_ch.byte_value};
                  crc_in      = crc_update(crc_eff, req_ch.byte_value);
               end
               default: begin
                  pos_in                   = 3'd0;
                  crc_in                   = CrcInit;
                  push                     = 1'b1;
                  push_job.raw_temperature = temp_word_ff;
                  push_job.raw_humidity    = hum_word_ff;
                  push_job.status = (first_good_ff && (crc_eff == req_ch.byte_value))
                                    ? STATUS_OK : STATUS_CRC_BAD;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= 3'd0;
         crc_ff        <= CrcInit;
         temp_word_ff  <= 16'd0;
         hum_word_ff   <= 16'd0;
         first_good_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         crc_ff        <= crc_in;
         temp_word_ff  <= temp_word_in;
         hum_word_ff   <= hum_word_in;
         first_good_ff <= first_good_in;
      end
   end

endmodule

// ----- hdl/htfc_fifo.sv -----
module htfc_fifo #(
   parameter int Depth = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  htfc_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output htfc_pkg::job_type head_job
);
   import htfc_pkg::*;

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(Depth);

   job_type               store [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;

   assign full      = (count_ff == FullCnt);
   assign not_empty = (count_ff != '0);
   assign head_job  = store[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hdl/htfc_scale.sv -----
module htfc_scale (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  htfc_pkg::job_type job,
   output logic              job_take,
   htfc_rsp_if.source        rsp_ch
);
   import htfc_pkg::*;

   localparam logic [14:0] TempGain   = 15'd17500;
   localparam logic [13:0] HumGain    = 14'd10000;
   localparam logic [14:0] TempOffset = 15'd4500;
   localparam logic [16:0] Divisor    = 17'd65535;

   // Stage 1: products.
   logic        v1_ff;
   job_type     job1_ff;
   logic [30:0] tprod1_ff;
   logic [29:0] hprod1_ff;

   // Stage 2: quotient estimates and remainders for the divide by 65535.
   logic        v2_ff;
   job_type     job2_ff;
   logic [14:0] tq2_ff, tq2_in;
   logic [13:0] hq2_ff, hq2_in;
   logic [16:0] tr2_ff, tr2_in;
   logic [16:0] hr2_ff, hr2_in;

   // Stage 3: response register.
   logic               v3_ff;
   status_type         status3_ff;
   logic signed [14:0] temp3_ff, temp3_in;
   logic [13:0]        hum3_ff, hum3_in;
   logic [15:0]        rawt3_ff, rawh3_ff;

   logic        ready1, ready2, ready3;
   logic [31:0] tsum;
   logic [30:0] hsum;
   logic [30:0] trem_full;
   logic [29:0] hrem_full;
   logic [14:0] tq_fix;
   logic [13:0] hq_fix;

   assign ready3   = !v3_ff || rsp_ch.ready;
   assign ready2   = !v2_ff || ready3;
   assign ready1   = !v1_ff || ready2;
   assign job_take = job_valid && ready1;

   // x / 65535 ~ (x + x/65536) / 65536; never above the true quotient, at most one below.
   always_comb begin
      tsum      = {1'b0, tprod1_ff} + {17'd0, tprod1_ff[30:16]};
      hsum      = {1'b0, hprod1_ff} + {17'd0, hprod1_ff[29:16]};
      tq2_in    = tsum[30:16];
      hq2_in    = hsum[29:16];
      trem_full = tprod1_ff - {tq2_in, 16'd0} + {16'd0, tq2_in};
      hrem_full = hprod1_ff - {hq2_in, 16'd0} + {16'd0, hq2_in};
      tr2_in    = trem_full[16:0];
      hr2_in    = hrem_full[16:0];
   end

   always_comb begin
      tq_fix   = tq2_ff + ((tr2_ff >= Divisor) ? 15'd1 : 15'd0);
      hq_fix   = hq2_ff + ((hr2_ff >= Divisor) ? 14'd1 : 14'd0);
      temp3_in = '0;
      hum3_in  = '0;
      if (job2_ff.status == STATUS_OK) begin
         temp3_in = $signed(tq_fix - TempOffset);
         hum3_in  = hq_fix;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         job1_ff   <= job;
         tprod1_ff <= {15'd0, job.raw_temperature} * {16'd0, TempGain};
         hprod1_ff <= {14'd0, job.raw_humidity} * {16'd0, HumGain};
      end
      if (ready2) begin
         job2_ff <= job1_ff;
         tq2_ff  <= tq2_in;
         hq2_ff  <= hq2_in;
         tr2_ff  <= tr2_in;
         hr2_ff  <= hr2_in;
      end
      if (ready3) begin
         status3_ff <= job2_ff.status;
         temp3_ff   <= temp3_in;
         hum3_ff    <= hum3_in;
         rawt3_ff   <= job2_ff.raw_temperature;
         rawh3_ff   <= job2_ff.raw_humidity;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ready1) v1_ff <= job_take;
         if (ready2) v2_ff <= v1_ff;
         if (ready3) v3_ff <= v2_ff;
      end
   end

   assign rsp_ch.valid             = v3_ff;
   assign rsp_ch.status            = status3_ff;
   assign rsp_ch.temperature_centi = temp3_ff;
   assign rsp_ch.humidity_centi    = hum3_ff;
   assign rsp_ch.raw_temperature   = rawt3_ff;
   assign rsp_ch.raw_humidity      = rawh3_ff;

endmodule
